### rtl/msc_pkg.sv
// Shared types, defaults and the marching-squares edge table.
package msc_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;

  typedef enum logic [1:0] {
    EDGE_BOTTOM,
    EDGE_RIGHT,
    EDGE_TOP,
    EDGE_LEFT
  } edge_t;

  typedef enum logic {
    AXIS_X,
    AXIS_Y
  } axis_t;

  // Per-endpoint control that rides along the divider pipeline.
  typedef struct packed {
    logic  neg;
    logic  flat;
    axis_t axis;
  } lane_ctl_t;

  function automatic logic [1:0] seg_count(input logic [3:0] cell_case);
    logic [1:0] cnt;
    case (cell_case)
      4'd0, 4'd15: cnt = 2'd0;
      4'd6, 4'd9:  cnt = 2'd2;
      default:     cnt = 2'd1;
    endcase
    return cnt;
  endfunction

  // Returns {start edge, end edge} of segment seg of the given case.
  function automatic logic [3:0] seg_edges(input logic [3:0] cell_case, input logic seg);
    logic [7:0] row;
    case (cell_case)
      4'd1, 4'd14: row = {EDGE_BOTTOM, EDGE_LEFT,  EDGE_BOTTOM, EDGE_BOTTOM};
      4'd2, 4'd13: row = {EDGE_BOTTOM, EDGE_RIGHT, EDGE_BOTTOM, EDGE_BOTTOM};
      4'd3, 4'd12: row = {EDGE_RIGHT,  EDGE_LEFT,  EDGE_BOTTOM, EDGE_BOTTOM};
      4'd4, 4'd11: row = {EDGE_TOP,    EDGE_LEFT,  EDGE_BOTTOM, EDGE_BOTTOM};
      4'd5, 4'd10: row = {EDGE_BOTTOM, EDGE_TOP,   EDGE_BOTTOM, EDGE_BOTTOM};
      4'd6:        row = {EDGE_BOTTOM, EDGE_RIGHT, EDGE_TOP,    EDGE_LEFT};
      4'd7, 4'd8:  row = {EDGE_RIGHT,  EDGE_TOP,   EDGE_BOTTOM, EDGE_BOTTOM};
      4'd9:        row = {EDGE_BOTTOM, EDGE_LEFT,  EDGE_RIGHT,  EDGE_TOP};
      default:     row = {EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM};
    endcase
    return seg ? row[3:0] : row[7:4];
  endfunction

endpackage

### rtl/msc_issue.sv
// Cell register, segment issue, operand setup and sign/magnitude prep stages.
module msc_issue
  import msc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [DATA_WIDTH-1:0]        iso_level,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [DATA_WIDTH-1:0]        in_val_a,
  input  logic [DATA_WIDTH-1:0]        in_val_b,
  input  logic [DATA_WIDTH-1:0]        in_val_c,
  input  logic [DATA_WIDTH-1:0]        in_val_d,
  input  logic [DATA_WIDTH-1:0]        in_x_left,
  input  logic [DATA_WIDTH-1:0]        in_x_right,
  input  logic [DATA_WIDTH-1:0]        in_y_bottom,
  input  logic [DATA_WIDTH-1:0]        in_y_top,
  input  logic                         dn_ready,
  output logic                         dn_valid,
  output logic                         dn_last,
  output lane_ctl_t [1:0]              dn_ctl,
  output logic [1:0][DATA_WIDTH:0]     dn_un,
  output logic [1:0][DATA_WIDTH:0]     dn_ud,
  output logic [1:0][DATA_WIDTH:0]     dn_us,
  output logic [1:0][DATA_WIDTH-1:0]   dn_p0,
  output logic [1:0][DATA_WIDTH-1:0]   dn_fixed
);

  localparam int W = DATA_WIDTH;

  function automatic logic [W:0] mag(input logic [W:0] x);
    return x[W] ? (~x + 1'b1) : x;
  endfunction

  // cell register
  logic                cell_v_r, cell_v_nxt;
  logic                seg_r, seg_nxt;
  logic [3:0]          case_r, case_nxt;
  logic [3:0][W-1:0]   val_r;
  logic [W-1:0]        xl_r, xr_r, yb_r, yt_r;

  logic [1:0]          cnt;
  logic                last, emit, done, cell_load, a_en, b_en;
  logic [3:0]          edges;
  edge_t [1:0]         lane_edge;

  // stage A: raw differences
  logic                a_v_r, a_last_r;
  logic [1:0][W:0]     a_n_r, a_d_r, a_s_r, a_n_nxt, a_d_nxt, a_s_nxt;
  logic [1:0][W-1:0]   a_p0_r, a_fx_r, a_p0_nxt, a_fx_nxt, a_p1;
  logic [1:0][W-1:0]   a_v0, a_v1;
  axis_t [1:0]         a_ax_r, a_ax_nxt;

  // stage B: magnitudes and sign
  logic                b_v_r, b_last_r;
  lane_ctl_t [1:0]     b_ctl_r, b_ctl_nxt;
  logic [1:0][W:0]     b_un_r, b_ud_r, b_us_r, b_un_nxt, b_ud_nxt, b_us_nxt, n_mag;
  logic [1:0][W-1:0]   b_p0_r, b_fx_r;

  assign case_nxt = {$signed(in_val_d) > $signed(iso_level),
                     $signed(in_val_c) > $signed(iso_level),
                     $signed(in_val_b) > $signed(iso_level),
                     $signed(in_val_a) > $signed(iso_level)};

  assign b_en      = !b_v_r || dn_ready;
  assign a_en      = !a_v_r || b_en;
  assign cnt       = seg_count(case_r);
  assign last      = (cnt != 2'd2) || seg_r;
  assign emit      = cell_v_r && (cnt != 2'd0);
  // drop cells with no crossing without waiting on the pipeline
  assign done      = cell_v_r && ((cnt == 2'd0) || (a_en && last));
  assign cell_load = !cell_v_r || done;
  assign in_stall  = !cell_load;

  assign cell_v_nxt = cell_load ? in_valid : 1'b1;
  assign seg_nxt    = cell_load ? 1'b0 : (seg_r | (emit && a_en));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_v_r <= 1'b0;
      seg_r    <= 1'b0;
    end else begin
      cell_v_r <= cell_v_nxt;
      seg_r    <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cell_load && in_valid) begin
      case_r <= case_nxt;
      val_r  <= {in_val_d, in_val_c, in_val_b, in_val_a};
      xl_r   <= in_x_left;
      xr_r   <= in_x_right;
      yb_r   <= in_y_bottom;
      yt_r   <= in_y_top;
    end
  end

  assign edges        = seg_edges(case_r, seg_r);
  assign lane_edge[0] = edge_t'(edges[3:2]);
  assign lane_edge[1] = edge_t'(edges[1:0]);

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      case (lane_edge[i])
        EDGE_BOTTOM: begin
          a_p0_nxt[i] = xl_r;     a_p1[i] = xr_r;
          a_v0[i]     = val_r[0]; a_v1[i] = val_r[1];
          a_ax_nxt[i] = AXIS_X;   a_fx_nxt[i] = yb_r;
        end
        EDGE_RIGHT: begin
          a_p0_nxt[i] = yb_r;     a_p1[i] = yt_r;
          a_v0[i]     = val_r[1]; a_v1[i] = val_r[3];
          a_ax_nxt[i] = AXIS_Y;   a_fx_nxt[i] = xr_r;
        end
        EDGE_TOP: begin
          a_p0_nxt[i] = xl_r;     a_p1[i] = xr_r;
          a_v0[i]     = val_r[2]; a_v1[i] = val_r[3];
          a_ax_nxt[i] = AXIS_X;   a_fx_nxt[i] = yt_r;
        end
        default: begin
          a_p0_nxt[i] = yb_r;     a_p1[i] = yt_r;
          a_v0[i]     = val_r[0]; a_v1[i] = val_r[2];
          a_ax_nxt[i] = AXIS_Y;   a_fx_nxt[i] = xl_r;
        end
      endcase
      a_n_nxt[i] = {iso_level[W-1], iso_level} - {a_v0[i][W-1], a_v0[i]};
      a_d_nxt[i] = {a_v1[i][W-1], a_v1[i]} - {a_v0[i][W-1], a_v0[i]};
      a_s_nxt[i] = {a_p1[i][W-1], a_p1[i]} - {a_p0_nxt[i][W-1], a_p0_nxt[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (a_en) begin
      a_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_last_r <= last;
      a_n_r    <= a_n_nxt;
      a_d_r    <= a_d_nxt;
      a_s_r    <= a_s_nxt;
      a_p0_r   <= a_p0_nxt;
      a_fx_r   <= a_fx_nxt;
      a_ax_r   <= a_ax_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      n_mag[i]    = mag(a_n_r[i]);
      b_ud_nxt[i] = mag(a_d_r[i]);
      b_us_nxt[i] = mag(a_s_r[i]);
      b_un_nxt[i] = (n_mag[i] > b_ud_nxt[i]) ? b_ud_nxt[i] : n_mag[i];
      b_ctl_nxt[i].neg  = a_n_r[i][W] ^ a_d_r[i][W] ^ a_s_r[i][W];
      b_ctl_nxt[i].flat = (a_d_r[i] == '0);
      b_ctl_nxt[i].axis = a_ax_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (b_en) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_en) begin
      b_last_r <= a_last_r;
      b_ctl_r  <= b_ctl_nxt;
      b_un_r   <= b_un_nxt;
      b_ud_r   <= b_ud_nxt;
      b_us_r   <= b_us_nxt;
      b_p0_r   <= a_p0_r;
      b_fx_r   <= a_fx_r;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_last  = b_last_r;
  assign dn_ctl   = b_ctl_r;
  assign dn_un    = b_un_r;
  assign dn_ud    = b_ud_r;
  assign dn_us    = b_us_r;
  assign dn_p0    = b_p0_r;
  assign dn_fixed = b_fx_r;

`ifndef SYNTHESIS
  a_second_seg_only_saddle: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_v_r && seg_r) |-> (seg_count(case_r) == 2'd2))
    else $error("second segment pending on a cell without two segments");

  a_crossed_edge_not_flat: assert property (@(posedge clk) disable iff (!rst_n)
    b_v_r |-> (!b_ctl_r[0].flat && !b_ctl_r[1].flat))
    else $error("crossed edge with equal corner values");
`endif

endmodule

### rtl/msc_muldiv.sv
// Pipelined bit-serial multiply-divide, one multiplier bit per stage, two lanes.
module msc_muldiv
  import msc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic                         up_last,
  input  lane_ctl_t [1:0]              up_ctl,
  input  logic [1:0][DATA_WIDTH:0]     up_un,
  input  logic [1:0][DATA_WIDTH:0]     up_ud,
  input  logic [1:0][DATA_WIDTH:0]     up_us,
  input  logic [1:0][DATA_WIDTH-1:0]   up_p0,
  input  logic [1:0][DATA_WIDTH-1:0]   up_fixed,
  input  logic                         dn_ready,
  output logic                         dn_valid,
  output logic                         dn_last,
  output lane_ctl_t [1:0]              dn_ctl,
  output logic [1:0][DATA_WIDTH:0]     dn_q,
  output logic [1:0][DATA_WIDTH-1:0]   dn_p0,
  output logic [1:0][DATA_WIDTH-1:0]   dn_fixed
);

  localparam int W  = DATA_WIDTH;
  localparam int NS = DATA_WIDTH + 1;

  logic [NS-1:0]      v_r;
  logic [NS-1:0]      last_r;
  logic [NS:0]        en;
  lane_ctl_t [1:0]    ctl_r [NS];
  logic [1:0][W:0]    un_r [NS];
  logic [1:0][W:0]    ud_r [NS];
  logic [1:0][W:0]    us_r [NS];
  logic [1:0][W:0]    q_r [NS];
  logic [1:0][W-1:0]  rem_r [NS];
  logic [1:0][W-1:0]  p0_r [NS];
  logic [1:0][W-1:0]  fx_r [NS];

  assign en[NS]   = dn_ready;
  assign up_ready = en[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic              sv, slast;
    lane_ctl_t [1:0]   sctl;
    logic [1:0][W:0]   sun, sud, sus, sq, q_nxt, dbl, r1;
    logic [1:0][W-1:0] srem, sp0, sfx, rem_nxt;
    logic [1:0][W+1:0] sum2, r2;
    logic [1:0]        ge1, ge2;

    if (k == 0) begin : g_first
      assign sv    = up_valid;
      assign slast = up_last;
      assign sctl  = up_ctl;
      assign sun   = up_un;
      assign sud   = up_ud;
      assign sus   = up_us;
      assign sq    = '0;
      assign srem  = '0;
      assign sp0   = up_p0;
      assign sfx   = up_fixed;
    end else begin : g_next
      assign sv    = v_r[k-1];
      assign slast = last_r[k-1];
      assign sctl  = ctl_r[k-1];
      assign sun   = un_r[k-1];
      assign sud   = ud_r[k-1];
      assign sus   = us_r[k-1];
      assign sq    = q_r[k-1];
      assign srem  = rem_r[k-1];
      assign sp0   = p0_r[k-1];
      assign sfx   = fx_r[k-1];
    end

    // a stage takes new data when empty or when its contents move on
    assign en[k] = !v_r[k] || en[k+1];

    // remainder stays below the divisor, so each step subtracts it at most twice
    always_comb begin
      for (int i = 0; i < 2; i++) begin
        dbl[i]  = {srem[i], 1'b0};
        ge1[i]  = (dbl[i] >= sud[i]);
        r1[i]   = ge1[i] ? (dbl[i] - sud[i]) : dbl[i];
        sum2[i] = sus[i][W-k] ? ({1'b0, r1[i]} + {1'b0, sun[i]}) : {1'b0, r1[i]};
        ge2[i]  = (sum2[i] >= {1'b0, sud[i]});
        r2[i]   = ge2[i] ? (sum2[i] - {1'b0, sud[i]}) : sum2[i];
        rem_nxt[i] = r2[i][W-1:0];
        q_nxt[i]   = {sq[i][W-1:0], 1'b0} + (W+1)'(ge1[i]) + (W+1)'(ge2[i]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= sv;
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        last_r[k] <= slast;
        ctl_r[k]  <= sctl;
        un_r[k]   <= sun;
        ud_r[k]   <= sud;
        us_r[k]   <= sus;
        q_r[k]    <= q_nxt;
        rem_r[k]  <= rem_nxt;
        p0_r[k]   <= sp0;
        fx_r[k]   <= sfx;
      end
    end
  end

  assign dn_valid = v_r[NS-1];
  assign dn_last  = last_r[NS-1];
  assign dn_ctl   = ctl_r[NS-1];
  assign dn_q     = q_r[NS-1];
  assign dn_p0    = p0_r[NS-1];
  assign dn_fixed = fx_r[NS-1];

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> (({1'b0, rem_r[NS-1][0]} < ud_r[NS-1][0]) &&
                   ({1'b0, rem_r[NS-1][1]} < ud_r[NS-1][1])))
    else $error("divider remainder not below divisor");

  a_quot_within_span: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[NS-1] |-> ((q_r[NS-1][0] <= us_r[NS-1][0]) && (q_r[NS-1][1] <= us_r[NS-1][1])))
    else $error("interpolation offset exceeds edge length");
`endif

endmodule

### rtl/msc_out.sv
// Endpoint offset, saturation and the result output register.
module msc_out
  import msc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic                         up_last,
  input  lane_ctl_t [1:0]              up_ctl,
  input  logic [1:0][DATA_WIDTH:0]     up_q,
  input  logic [1:0][DATA_WIDTH-1:0]   up_p0,
  input  logic [1:0][DATA_WIDTH-1:0]   up_fixed,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [DATA_WIDTH-1:0]        out_start_x,
  output logic [DATA_WIDTH-1:0]        out_start_y,
  output logic [DATA_WIDTH-1:0]        out_end_x,
  output logic [DATA_WIDTH-1:0]        out_end_y,
  output logic                         out_last_segment
);

  localparam int W = DATA_WIDTH;

  logic [1:0][W+1:0] sum;
  logic [1:0][W-1:0] res, sat, px, py;
  logic [1:0]        ovf;

  logic              out_valid_r;
  logic [W-1:0]      sx_r, sy_r, ex_r, ey_r;
  logic              last_r;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      sum[i] = up_ctl[i].neg ? ({{2{up_p0[i][W-1]}}, up_p0[i]} - {1'b0, up_q[i]})
                             : ({{2{up_p0[i][W-1]}}, up_p0[i]} + {1'b0, up_q[i]});
      ovf[i] = !((sum[i][W+1] == sum[i][W]) && (sum[i][W] == sum[i][W-1]));
      sat[i] = sum[i][W+1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      if (up_ctl[i].flat) begin
        res[i] = up_p0[i];
      end else if (ovf[i]) begin
        res[i] = sat[i];
      end else begin
        res[i] = sum[i][W-1:0];
      end
      px[i] = (up_ctl[i].axis == AXIS_X) ? res[i] : up_fixed[i];
      py[i] = (up_ctl[i].axis == AXIS_Y) ? res[i] : up_fixed[i];
    end
  end

  assign up_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (up_ready) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      sx_r   <= px[0];
      sy_r   <= py[0];
      ex_r   <= px[1];
      ey_r   <= py[1];
      last_r <= up_last;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_start_x      = sx_r;
  assign out_start_y      = sy_r;
  assign out_end_x        = ex_r;
  assign out_end_y        = ey_r;
  assign out_last_segment = last_r;

endmodule

### rtl/marching_squares_cell_unit.sv
// Marching-squares cell unit: threshold register and the segment pipeline.
//
// Usage: each input item is one grid cell, four corner scalars plus the cell
// bounds, all signed fixed point. Each corner is classified against the
// threshold register (strictly greater is inside); the cell then yields zero,
// one or two segments, each a result item with interpolated endpoints and a
// flag on the cell's final segment. Cells with no crossing yield nothing.
// Both channels use valid/stall; an item moves when valid is high and stall
// is low. The threshold is to be written through cfg_wr_en/cfg_wr_data only
// while idle; the block does not enforce this. Each segment passes through
// the cell register, stages A and B, the divider and the output register; a
// saddle cell's second segment issues after the first. Throughput: the cell
// register issues one segment per cycle unless the pipeline stalls, into a
// divider pipeline of DATA_WIDTH+1 stages, one multiplier bit each. Reset
// clears all valid bits and loads the threshold with 3.2. A stalled output
// holds its result; empty stages ahead of it keep filling, and in_stall
// rises when the pipeline is full or while a saddle cell issues its first.
module marching_squares_cell_unit
  import msc_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [DATA_WIDTH-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_WIDTH-1:0] in_val_a,
  input  logic [DATA_WIDTH-1:0] in_val_b,
  input  logic [DATA_WIDTH-1:0] in_val_c,
  input  logic [DATA_WIDTH-1:0] in_val_d,
  input  logic [DATA_WIDTH-1:0] in_x_left,
  input  logic [DATA_WIDTH-1:0] in_x_right,
  input  logic [DATA_WIDTH-1:0] in_y_bottom,
  input  logic [DATA_WIDTH-1:0] in_y_top,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_WIDTH-1:0] out_start_x,
  output logic [DATA_WIDTH-1:0] out_start_y,
  output logic [DATA_WIDTH-1:0] out_end_x,
  output logic [DATA_WIDTH-1:0] out_end_y,
  output logic                  out_last_segment
);

  localparam int W = DATA_WIDTH;
  // 3.2 rounded to the nearest step of the fraction
  localparam longint ISO_RESET = ((longint'(16) << FRAC_BITS) + 2) / 5;
  localparam logic [W-1:0] ISO_RESET_W = ISO_RESET[W-1:0];

  logic [W-1:0]      iso_level_r, iso_level_nxt;

  logic              p_valid, p_ready, p_last;
  lane_ctl_t [1:0]   p_ctl;
  logic [1:0][W:0]   p_un, p_ud, p_us;
  logic [1:0][W-1:0] p_p0, p_fixed;

  logic              d_valid, d_ready, d_last;
  lane_ctl_t [1:0]   d_ctl;
  logic [1:0][W:0]   d_q;
  logic [1:0][W-1:0] d_p0, d_fixed;

  assign iso_level_nxt = cfg_wr_en ? cfg_wr_data : iso_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_level_r <= ISO_RESET_W;
    end else begin
      iso_level_r <= iso_level_nxt;
    end
  end

  msc_issue #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_issue (
    .clk        (clk),
    .rst_n      (rst_n),
    .iso_level  (iso_level_r),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_val_a   (in_val_a),
    .in_val_b   (in_val_b),
    .in_val_c   (in_val_c),
    .in_val_d   (in_val_d),
    .in_x_left  (in_x_left),
    .in_x_right (in_x_right),
    .in_y_bottom(in_y_bottom),
    .in_y_top   (in_y_top),
    .dn_ready   (p_ready),
    .dn_valid   (p_valid),
    .dn_last    (p_last),
    .dn_ctl     (p_ctl),
    .dn_un      (p_un),
    .dn_ud      (p_ud),
    .dn_us      (p_us),
    .dn_p0      (p_p0),
    .dn_fixed   (p_fixed)
  );

  msc_muldiv #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_muldiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .up_valid(p_valid),
    .up_ready(p_ready),
    .up_last (p_last),
    .up_ctl  (p_ctl),
    .up_un   (p_un),
    .up_ud   (p_ud),
    .up_us   (p_us),
    .up_p0   (p_p0),
    .up_fixed(p_fixed),
    .dn_ready(d_ready),
    .dn_valid(d_valid),
    .dn_last (d_last),
    .dn_ctl  (d_ctl),
    .dn_q    (d_q),
    .dn_p0   (d_p0),
    .dn_fixed(d_fixed)
  );

  msc_out #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (d_valid),
    .up_ready        (d_ready),
    .up_last         (d_last),
    .up_ctl          (d_ctl),
    .up_q            (d_q),
    .up_p0           (d_p0),
    .up_fixed        (d_fixed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_last_segment(out_last_segment)
  );

endmodule

### test/testbench.sv
// Self-checking testbench for the marching-squares cell unit.
module testbench
  import msc_pkg::*;
();

  localparam int DW = DATA_WIDTH_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic [DW-1:0] va, vb, vc, vd;
    logic [DW-1:0] xl, xr, yb, yt;
  } cell_t;

  typedef struct {
    logic [DW-1:0] sx, sy, ex, ey;
    logic          last;
  } segment_t;

  class segment_board;
    longint   iso;
    segment_t segment_q[$];
    int       errors;
    int       printed;
    edge_t    route[16][4];
    int       seg_num[16];

    function new();
      iso = 819;  // 3.2 in Q8.8
      errors = 0;
      printed = 0;
      seg_num = '{0, 1, 1, 1, 1, 1, 2, 1, 1, 2, 1, 1, 1, 1, 1, 0};
      route = '{
        '{EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_RIGHT,  EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_TOP,    EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_TOP,    EDGE_LEFT},
        '{EDGE_RIGHT,  EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_RIGHT,  EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_LEFT,   EDGE_RIGHT,  EDGE_TOP},
        '{EDGE_BOTTOM, EDGE_TOP,    EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_TOP,    EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_RIGHT,  EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_RIGHT,  EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_LEFT,   EDGE_BOTTOM, EDGE_BOTTOM},
        '{EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM, EDGE_BOTTOM}};
    endfunction

    // Point on an edge where the scalar meets the threshold, rounded toward p0.
    function longint interp(longint p0, longint p1, longint v0, longint v1);
      longint num, den, span, q, r, hi;
      bit     neg;
      num = iso - v0;
      den = v1 - v0;
      span = p1 - p0;
      neg = 1'b0;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      if (den == 0) return p0;
      if (num < 0) begin
        neg = !neg;
        num = -num;
      end
      if (den < 0) begin
        neg = !neg;
        den = -den;
      end
      if (span < 0) begin
        neg = !neg;
        span = -span;
      end
      if (num > den) num = den;
      q = (num * span) / den;
      r = neg ? p0 - q : p0 + q;
      if (r > hi) r = hi;
      if (r < -hi - 1) r = -hi - 1;
      return r;
    endfunction

    function void locate(edge_t e, longint v[4], longint xl, longint xr, longint yb,
                         longint yt, output longint px, output longint py);
      case (e)
        EDGE_BOTTOM: begin
          px = interp(xl, xr, v[0], v[1]);
          py = yb;
        end
        EDGE_RIGHT: begin
          px = xr;
          py = interp(yb, yt, v[1], v[3]);
        end
        EDGE_TOP: begin
          px = interp(xl, xr, v[2], v[3]);
          py = yt;
        end
        default: begin
          px = xl;
          py = interp(yb, yt, v[0], v[2]);
        end
      endcase
    endfunction

    function void note_cell(cell_t c);
      longint   v[4];
      longint   xl, xr, yb, yt, sx, sy, ex, ey;
      int       cs;
      segment_t s;
      v[0] = longint'($signed(c.va));
      v[1] = longint'($signed(c.vb));
      v[2] = longint'($signed(c.vc));
      v[3] = longint'($signed(c.vd));
      xl = longint'($signed(c.xl));
      xr = longint'($signed(c.xr));
      yb = longint'($signed(c.yb));
      yt = longint'($signed(c.yt));
      cs = 0;
      for (int i = 0; i < 4; i++)
        if (v[i] > iso) cs |= 1 << i;
      for (int k = 0; k < seg_num[cs]; k++) begin
        locate(route[cs][2*k], v, xl, xr, yb, yt, sx, sy);
        locate(route[cs][2*k+1], v, xl, xr, yb, yt, ex, ey);
        s.sx = sx[DW-1:0];
        s.sy = sy[DW-1:0];
        s.ex = ex[DW-1:0];
        s.ey = ey[DW-1:0];
        s.last = (k + 1 == seg_num[cs]);
        segment_q.push_back(s);
      end
    endfunction

    task report(string msg);
      errors++;
      // cap the log on a badly broken block, keep counting
      if (printed < 100) begin
        printed++;
        $display("mismatch at %0t: %s", $realtime, msg);
      end
    endtask

    task check_segment(segment_t got);
      segment_t want;
      if (segment_q.size() == 0) begin
        report($sformatf("segment (%0d,%0d)-(%0d,%0d) with none expected",
                         $signed(got.sx), $signed(got.sy), $signed(got.ex), $signed(got.ey)));
        return;
      end
      want = segment_q.pop_front();
      if (got.sx !== want.sx)
        report($sformatf("start_x %0d, want %0d", $signed(got.sx), $signed(want.sx)));
      if (got.sy !== want.sy)
        report($sformatf("start_y %0d, want %0d", $signed(got.sy), $signed(want.sy)));
      if (got.ex !== want.ex)
        report($sformatf("end_x %0d, want %0d", $signed(got.ex), $signed(want.ex)));
      if (got.ey !== want.ey)
        report($sformatf("end_y %0d, want %0d", $signed(got.ey), $signed(want.ey)));
      if (got.last !== want.last)
        report($sformatf("last_segment %b, want %b", got.last, want.last));
    endtask
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          cfg_wr_en;
  logic [DW-1:0] cfg_wr_data;
  logic          in_valid;
  logic          in_stall;
  logic [DW-1:0] in_val_a, in_val_b, in_val_c, in_val_d;
  logic [DW-1:0] in_x_left, in_x_right, in_y_bottom, in_y_top;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic [DW-1:0] out_start_x, out_start_y, out_end_x, out_end_y;
  logic          out_last_segment;

  segment_board sb;
  int           send_pct;
  int           stall_pct;
  int           threshold;
  int           cycles = 0;

  marching_squares_cell_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_val_a        (in_val_a),
    .in_val_b        (in_val_b),
    .in_val_c        (in_val_c),
    .in_val_d        (in_val_d),
    .in_x_left       (in_x_left),
    .in_x_right      (in_x_right),
    .in_y_bottom     (in_y_bottom),
    .in_y_top        (in_y_top),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_start_x     (out_start_x),
    .out_start_y     (out_start_y),
    .out_end_x       (out_end_x),
    .out_end_y       (out_end_y),
    .out_last_segment(out_last_segment)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin : segment_sink
    segment_t got;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.sx = out_start_x;
      got.sy = out_start_y;
      got.ex = out_end_x;
      got.ey = out_end_y;
      got.last = out_last_segment;
      sb.check_segment(got);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic send_cell(cell_t c);
    in_valid <= 1'b1;
    in_val_a <= c.va;
    in_val_b <= c.vb;
    in_val_c <= c.vc;
    in_val_d <= c.vd;
    in_x_left <= c.xl;
    in_x_right <= c.xr;
    in_y_bottom <= c.yb;
    in_y_top <= c.yt;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_cell(c);
    while ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Drop valid, wait for every expected segment, then let the pipeline empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.segment_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(logic [DW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.iso = longint'($signed(v));
    threshold = int'($signed(v));
  endtask

  // Corners inside when the matching bit of the case is set.
  function automatic cell_t make_cell(logic [3:0] cs, int up, int dn,
                                      int xl, int xr, int yb, int yt);
    cell_t c;
    c.va = DW'(cs[0] ? up : dn);
    c.vb = DW'(cs[1] ? up : dn);
    c.vc = DW'(cs[2] ? up : dn);
    c.vd = DW'(cs[3] ? up : dn);
    c.xl = DW'(xl);
    c.xr = DW'(xr);
    c.yb = DW'(yb);
    c.yt = DW'(yt);
    return c;
  endfunction

  // Mostly near the threshold so that crossings are common.
  function automatic logic [DW-1:0] pick_corner(int iso);
    int sel, off, v;
    sel = $urandom_range(9);
    if (sel < 6) begin
      off = $urandom_range(2048);
      v = iso + off - 1024;
    end else if (sel < 8) begin
      return DW'($urandom);
    end else if (sel == 8) begin
      off = $urandom_range(2);
      v = iso + off - 1;
    end else begin
      return $urandom_range(1) ? 16'h7fff : 16'h8000;
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[DW-1:0];
  endfunction

  function automatic cell_t random_cell(int iso);
    cell_t c;
    int    sel;
    c.va = pick_corner(iso);
    c.vb = pick_corner(iso);
    c.vc = pick_corner(iso);
    c.vd = pick_corner(iso);
    c.xl = DW'($urandom);
    c.yb = DW'($urandom);
    sel = $urandom_range(9);
    c.xr = sel < 6 ? DW'($urandom) : sel < 9 ? c.xl + DW'($urandom_range(512)) : c.xl;
    sel = $urandom_range(9);
    c.yt = sel < 6 ? DW'($urandom) : sel < 9 ? c.yb + DW'($urandom_range(512)) : c.yb;
    return c;
  endfunction

  int iso_plan[6] = '{-32768, 0, 32767, 0, -300, 819};
  int size_plan[6] = '{170, 170, 40, 170, 170, 170};

  initial begin
    cell_t c;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_val_a = '0;
    in_val_b = '0;
    in_val_c = '0;
    in_val_d = '0;
    in_x_left = '0;
    in_x_right = '0;
    in_y_bottom = '0;
    in_y_top = '0;
    send_pct = 28;
    stall_pct = 77;
    threshold = 819;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every case at the reset threshold: extreme corners on even cases,
    // corners one step above or exactly on the threshold on odd ones.
    for (int cs = 0; cs < 16; cs++) begin
      if (cs % 2 == 0)
        send_cell(make_cell(4'(cs), 32767, -32768, -32768, 32767, -32768, 32767));
      else
        send_cell(make_cell(4'(cs), threshold + 1, threshold, 32767, -32768, 32767, -32768));
    end
    // saddle on a cell of zero size
    send_cell(make_cell(4'd9, 1000, -1000, 100, 100, -100, -100));
    c.va = 0;
    c.vb = 1000;
    c.vc = 2000;
    c.vd = 500;
    c.xl = 0;
    c.xr = 256;
    c.yb = 0;
    c.yt = 256;
    send_cell(c);
    // all corners exactly on the threshold count as outside
    send_cell(make_cell(4'd15, threshold, threshold, -1, 0, 0, -1));
    c.va = 16'h8000;
    c.vb = 16'h7fff;
    c.vc = DW'(threshold);
    c.vd = DW'(threshold + 1);
    c.xl = DW'(-1);
    c.xr = 0;
    c.yb = 0;
    c.yt = DW'(-1);
    send_cell(c);

    for (int b = 0; b < 6; b++) begin
      settle();
      if (b == 1 || b == 3) iso_plan[b] = int'($signed(DW'($urandom)));
      write_threshold(DW'(iso_plan[b]));
      send_pct = b < 2 ? 28 : b < 4 ? 77 : 0;
      stall_pct = b < 2 ? 77 : b < 4 ? 28 : 0;
      repeat (size_plan[b]) send_cell(random_cell(threshold));
    end
    settle();

    if (sb.errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule

### marching_squares_cell_unit.f
rtl/msc_pkg.sv
rtl/msc_issue.sv
rtl/msc_muldiv.sv
rtl/msc_out.sv
rtl/marching_squares_cell_unit.sv
test/testbench.sv
